/* rtl/umsk_pkg.sv */
// Shared types, constants and pixel math for the 3x3 unsharp mask block.
`default_nettype none

package umsk_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = 12;
  localparam int FW_W      = COL_W + 1;
  localparam int PIX_W     = 24;
  localparam int JOB_DEPTH = 4;
  localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
  localparam int JOB_CNT_W = JOB_PTR_W + 1;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 12;
  localparam int GAIN_W    = 12;
  localparam int OFFS_W    = 10;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLUR_GAIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET       = 3'd4;

  localparam logic [FW_W-1:0]   RST_FRAME_WIDTH  = FW_W'(640);
  localparam logic [ROW_W-1:0]  RST_FRAME_HEIGHT = ROW_W'(480);
  localparam logic [GAIN_W-1:0] RST_SOURCE_GAIN  = GAIN_W'(384);
  localparam logic [GAIN_W-1:0] RST_BLUR_GAIN    = 12'hF80;
  localparam logic [OFFS_W-1:0] RST_OFFSET       = '0;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0]       red_out;
    logic [7:0]       green_out;
    logic [7:0]       blue_out;
    logic [COL_W-1:0] out_col;
    logic [ROW_W-1:0] out_row;
    logic             frame_done;
  } res_out_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] source_gain;
    logic signed [GAIN_W-1:0] blur_gain;
    logic signed [OFFS_W-1:0] offset;
  } gain_cfg_t;

  // One input pixel's worth of results: bit 0 of en is the interior/left
  // neighbor result, bit 1 the right-edge result of the row above, bit 2
  // the last-row pass-through.
  typedef struct packed {
    logic [2:0]       en;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last_col;
    logic [PIX_W-1:0] src1;
    logic [PIX_W-1:0] blur1;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] px;
  } job_t;

  // 1 2 1 / 2 4 2 / 1 2 1 over 16, rounded half up, each channel on its own.
  function automatic logic [PIX_W-1:0] blur_px(
    input logic [PIX_W-1:0] nw, input logic [PIX_W-1:0] n, input logic [PIX_W-1:0] ne,
    input logic [PIX_W-1:0] w,  input logic [PIX_W-1:0] c, input logic [PIX_W-1:0] e,
    input logic [PIX_W-1:0] sw, input logic [PIX_W-1:0] s, input logic [PIX_W-1:0] se
  );
    logic [11:0]      acc;
    logic [PIX_W-1:0] res;
    res = '0;
    for (int k = 0; k < 3; k++) begin
      acc = 12'(nw[8*k +: 8]) + {3'd0, n[8*k +: 8], 1'b0} + 12'(ne[8*k +: 8])
          + {3'd0, w[8*k +: 8], 1'b0} + {2'd0, c[8*k +: 8], 2'd0}
          + {3'd0, e[8*k +: 8], 1'b0}
          + 12'(sw[8*k +: 8]) + {3'd0, s[8*k +: 8], 1'b0} + 12'(se[8*k +: 8])
          + 12'd8;
      res[8*k +: 8] = acc[11:4];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/umsk_front.sv */
// Front end: raster position, line stores, 3x3 window, blur and job build.
`default_nettype none

module umsk_front import umsk_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [FW_W-1:0]  frame_width,
  input  wire logic [ROW_W-1:0] frame_height,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire pix_in_t          in_word,
  output logic                  job_push,
  output job_t                  job_data,
  input  wire logic             job_full
);

  logic [PIX_W-1:0] older_mem [MAX_WIDTH];
  logic [PIX_W-1:0] newer_mem [MAX_WIDTH];

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [FW_W-1:0]  w_eff;
  logic [ROW_W-1:0] h_eff;
  logic [COL_W-1:0] c_eff;
  logic [ROW_W-1:0] r_eff;
  logic             last_col, last_row, accept;

  logic             a_valid_r, a_valid_nxt;
  logic [PIX_W-1:0] a_px_r;
  logic [COL_W-1:0] a_c_r;
  logic [ROW_W-1:0] a_r_r;
  logic             a_lastc_r, a_lastr_r;
  logic [PIX_W-1:0] rd_top_r, rd_mid_r;
  logic             a_go;

  logic [PIX_W-1:0] win0_r, win1_r, win2_r, win3_r, win4_r, win5_r;
  logic [PIX_W-1:0] blur;
  job_t             job;

  // Clamp the frame size and the position into range.
  always_comb begin
    if (frame_width < FW_W'(3)) w_eff = FW_W'(3);
    else if (frame_width > FW_W'(MAX_WIDTH)) w_eff = FW_W'(MAX_WIDTH);
    else w_eff = frame_width;
    h_eff = (frame_height < ROW_W'(3)) ? ROW_W'(3) : frame_height;
    c_eff = ({1'b0, col_r} >= w_eff) ? COL_W'(w_eff - FW_W'(1)) : col_r;
    r_eff = (row_r >= h_eff) ? (h_eff - ROW_W'(1)) : row_r;
    last_col = ({1'b0, c_eff} == (w_eff - FW_W'(1)));
    last_row = (r_eff == (h_eff - ROW_W'(1)));
  end

  assign accept = in_valid && !in_stall;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : r_eff + ROW_W'(1);
      end else begin
        col_nxt = c_eff + COL_W'(1);
        row_nxt = r_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Line stores: read on accept, write back once the item leaves stage A.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_top_r <= older_mem[c_eff];
      rd_mid_r <= newer_mem[c_eff];
    end
    if (a_go) begin
      older_mem[a_c_r] <= rd_mid_r;
      newer_mem[a_c_r] <= a_px_r;
    end
  end

  // Build the job of the item held in stage A.
  always_comb begin
    blur = blur_px(win3_r, win0_r, rd_top_r,
                   win4_r, win1_r, rd_mid_r,
                   win5_r, win2_r, a_px_r);
    job.en[0]    = (a_r_r != '0) && (a_c_r != '0);
    job.en[1]    = (a_r_r != '0) && a_lastc_r;
    job.en[2]    = a_lastr_r;
    job.col      = a_c_r;
    job.row      = a_r_r;
    job.last_col = a_lastc_r;
    job.src1     = win1_r;
    job.blur1    = ((a_r_r > ROW_W'(1)) && (a_c_r > COL_W'(1))) ? blur : win1_r;
    job.mid      = rd_mid_r;
    job.px       = a_px_r;
  end

  assign a_go     = a_valid_r && ((job.en == 3'b000) || !job_full);
  assign in_stall = a_valid_r && !a_go;
  assign job_push = a_go && (job.en != 3'b000);
  assign job_data = job;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (accept) a_valid_nxt = 1'b1;
    else if (a_go) a_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_px_r    <= in_word;
      a_c_r     <= c_eff;
      a_r_r     <= r_eff;
      a_lastc_r <= last_col;
      a_lastr_r <= last_row;
    end
  end

  // Shift the window one column as the item leaves stage A.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win0_r <= '0;
      win1_r <= '0;
      win2_r <= '0;
      win3_r <= '0;
      win4_r <= '0;
      win5_r <= '0;
    end else if (a_go) begin
      win3_r <= win0_r;
      win4_r <= win1_r;
      win5_r <= win2_r;
      win0_r <= rd_top_r;
      win1_r <= rd_mid_r;
      win2_r <= a_px_r;
    end
  end

endmodule

`default_nettype wire

/* rtl/umsk_queue.sv */
// Short job queue between the front end and the weighting back end.
`default_nettype none

module umsk_queue import umsk_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_data,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output job_t      head_data
);

  job_t                 mem [JOB_DEPTH];
  logic [JOB_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [JOB_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [JOB_CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == JOB_CNT_W'(JOB_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + JOB_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + JOB_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) count_nxt = count_r + JOB_CNT_W'(1);
    else if (pop && !push) count_nxt = count_r - JOB_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

endmodule

`default_nettype wire

/* rtl/umsk_back.sv */
// Back end: unpack jobs into results, weight, round, saturate, output register.
`default_nettype none

module umsk_back import umsk_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire gain_cfg_t gains,
  input  wire logic      head_valid,
  input  wire job_t      head_data,
  output logic           pop,
  output logic           out_valid,
  input  wire logic      out_stall,
  output res_out_t       out_word
);

  logic [2:0]       used_r, used_nxt;
  logic [2:0]       rem, pick;
  logic [PIX_W-1:0] sel_src, sel_blur;
  logic [COL_W-1:0] sel_col;
  logic [ROW_W-1:0] sel_row;
  logic             sel_done;
  logic             load_p, p_move;

  logic                     p_valid_r, p_valid_nxt;
  logic signed [20:0]       p_pa_r [3];
  logic signed [20:0]       p_pb_r [3];
  logic [COL_W-1:0]         p_col_r;
  logic [ROW_W-1:0]         p_row_r;
  logic                     p_done_r;

  logic                     out_valid_r, out_valid_nxt;
  res_out_t                 out_word_r;
  logic signed [22:0]       t [3];
  logic [7:0]               q [3];

  // Pick the next pending result of the head job, in schedule order.
  always_comb begin
    rem      = head_data.en & ~used_r;
    pick     = 3'b100;
    sel_src  = head_data.px;
    sel_blur = head_data.px;
    sel_col  = head_data.col;
    sel_row  = head_data.row;
    sel_done = head_data.last_col;
    priority if (rem[0]) begin
      pick     = 3'b001;
      sel_src  = head_data.src1;
      sel_blur = head_data.blur1;
      sel_col  = head_data.col - COL_W'(1);
      sel_row  = head_data.row - ROW_W'(1);
      sel_done = 1'b0;
    end else if (rem[1]) begin
      pick     = 3'b010;
      sel_src  = head_data.mid;
      sel_blur = head_data.mid;
      sel_row  = head_data.row - ROW_W'(1);
      sel_done = 1'b0;
    end else begin
      pick     = 3'b100;
    end
  end

  assign p_move = p_valid_r && (!out_valid_r || !out_stall);
  assign load_p = head_valid && (!p_valid_r || p_move);
  assign pop    = load_p && ((rem & ~pick) == 3'b000);

  always_comb begin
    used_nxt = used_r;
    if (load_p) used_nxt = pop ? 3'b000 : (used_r | pick);
    p_valid_nxt = p_valid_r;
    if (load_p) p_valid_nxt = 1'b1;
    else if (p_move) p_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (p_move) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      used_r      <= used_nxt;
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Product stage: two 12x9 signed multiplies per channel.
  always_ff @(posedge clk) begin
    if (load_p) begin
      for (int k = 0; k < 3; k++) begin
        p_pa_r[k] <= gains.source_gain * $signed({1'b0, sel_src[8*k +: 8]});
        p_pb_r[k] <= gains.blur_gain * $signed({1'b0, sel_blur[8*k +: 8]});
      end
      p_col_r  <= sel_col;
      p_row_r  <= sel_row;
      p_done_r <= sel_done;
    end
  end

  // Sum, round half up, saturate to 0..255.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      t[k] = {{2{p_pa_r[k][20]}}, p_pa_r[k]} + {{2{p_pb_r[k][20]}}, p_pb_r[k]}
           + {{5{gains.offset[OFFS_W-1]}}, gains.offset, 8'd0} + 23'sd128;
      if (t[k][22]) q[k] = 8'd0;
      else if (t[k][21:16] != '0) q[k] = 8'd255;
      else q[k] = t[k][15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (p_move) begin
      out_word_r.red_out    <= q[2];
      out_word_r.green_out  <= q[1];
      out_word_r.blue_out   <= q[0];
      out_word_r.out_col    <= p_col_r;
      out_word_r.out_row    <= p_row_r;
      out_word_r.frame_done <= p_done_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

/* rtl/unsharp_mask_3x3_rgb.sv */
// Top level of the 3x3 Gaussian unsharp mask for an RGB raster stream.
//
// Usage: feed RGB pixels in raster order on in_word with in_valid; a pixel is
// taken on a rising edge with in_valid high and in_stall low. Results leave on
// out_word under the same valid/stall rule, each with its column and row;
// frame_done marks the last result of a frame. Results of the last row come
// out as their pixels arrive, so the result order is not plain raster order.
// Throughput: one pixel per clock on ordinary rows. A pixel on row 0 gives no
// result, a pixel at the end of a later row gives two, on the last row up to
// three; the front end and back end are parted by a 4-job queue, and the back
// end's weighting datapath delivers one result per clock unless out_stall is
// high, so in_stall rises only when the queue fills; on the last row that paces
// the input. A pixel's first result passes stage A with the line store read,
// the queue, the product stage and the output register. Reset (rst_n low,
// synchronous) clears position, window, queue and pipeline and loads registers
// to 640 x 480, gains 384 and -128, offset 0; the line stores are not cleared.
// When the receiver holds out_stall, the output word holds, the pipeline
// backs up into the queue and then stalls the input. Configuration is written
// through cfg_we/cfg_index/cfg_data only while idle, which the user must ensure.
`default_nettype none

module unsharp_mask_3x3_rgb import umsk_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire pix_in_t               in_word,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output res_out_t                   out_word,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [FW_W-1:0]   frame_width_r;
  logic [ROW_W-1:0]  frame_height_r;
  logic [GAIN_W-1:0] source_gain_r;
  logic [GAIN_W-1:0] blur_gain_r;
  logic [OFFS_W-1:0] offset_r;
  gain_cfg_t         gains;

  logic job_push, job_full, job_pop, head_valid;
  job_t job_data, head_data;

  // Register file: unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= RST_FRAME_WIDTH;
      frame_height_r <= RST_FRAME_HEIGHT;
      source_gain_r  <= RST_SOURCE_GAIN;
      blur_gain_r    <= RST_BLUR_GAIN;
      offset_r       <= RST_OFFSET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data[ROW_W-1:0];
        REG_SOURCE_GAIN:  source_gain_r  <= cfg_data[GAIN_W-1:0];
        REG_BLUR_GAIN:    blur_gain_r    <= cfg_data[GAIN_W-1:0];
        REG_OFFSET:       offset_r       <= cfg_data[OFFS_W-1:0];
        default: ;
      endcase
    end
  end

  assign gains.source_gain = $signed(source_gain_r);
  assign gains.blur_gain   = $signed(blur_gain_r);
  assign gains.offset      = $signed(offset_r);

  // Front end: position tracking, line stores, window and blur.
  umsk_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_word      (in_word),
    .job_push     (job_push),
    .job_data     (job_data),
    .job_full     (job_full)
  );

  // Decouple the bursty job stream from the back end, one result per clock unless out_stall holds it.
  umsk_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (job_push),
    .push_data  (job_data),
    .full       (job_full),
    .pop        (job_pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  // Back end: weighting, rounding, saturation and the output register.
  umsk_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .gains      (gains),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (job_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word)
  );

endmodule

`default_nettype wire
